// ===== rtl/core/json_scalar_token_scanner_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef JSON_SCALAR_TOKEN_SCANNER_MACROS_SVH
`define JSON_SCALAR_TOKEN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define JSTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanner assertion failed");
// Next-cycle implication, disabled during reset.
`define JSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner assertion failed");
`else
`define JSTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define JSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/jsts_pkg.sv =====
// Types, codes and character helpers for the JSON scalar scanner.
package jsts_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_STR      = 4'd1,
    PH_STR_ESC  = 4'd2,
    PH_NUM_SIGN = 4'd3,
    PH_NUM_INT  = 4'd4,
    PH_NUM_DOT  = 4'd5,
    PH_NUM_FRAC = 4'd6,
    PH_NUM_E    = 4'd7,
    PH_NUM_ESGN = 4'd8,
    PH_NUM_EXP  = 4'd9,
    PH_KEYWORD  = 4'd10,
    PH_DONE     = 4'd11
  } phase_t;

  typedef logic [2:0] kind_t;
  localparam kind_t K_STRING = 3'd0;
  localparam kind_t K_NUMBER = 3'd1;
  localparam kind_t K_TRUE   = 3'd2;
  localparam kind_t K_FALSE  = 3'd3;
  localparam kind_t K_NULL   = 3'd4;

  typedef logic [2:0] err_t;
  localparam err_t ERR_OK          = 3'd0;
  localparam err_t ERR_BAD_START   = 3'd1;
  localparam err_t ERR_BAD_ESCAPE  = 3'd2;
  localparam err_t ERR_UNTERM      = 3'd3;
  localparam err_t ERR_BAD_NUMBER  = 3'd4;
  localparam err_t ERR_BAD_BOOLEAN = 3'd5;
  localparam err_t ERR_BAD_NULL    = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Returns {supported, mapped byte} for the letter after a backslash.
  function automatic logic [8:0] map_escape(input logic [7:0] c);
    logic [8:0] res;
    res = 9'd0;
    unique case (c)
      CH_QUOTE:  res = {1'b1, CH_QUOTE};
      CH_BSLASH: res = {1'b1, CH_BSLASH};
      CH_SLASH:  res = {1'b1, CH_SLASH};
      8'h62:     res = {1'b1, 8'h08};
      8'h66:     res = {1'b1, 8'h0C};
      8'h6E:     res = {1'b1, 8'h0A};
      8'h72:     res = {1'b1, 8'h0D};
      8'h74:     res = {1'b1, 8'h09};
      default:   res = 9'd0;
    endcase
    return res;
  endfunction

  function automatic logic [2:0] keyword_len(input kind_t k);
    return (k == K_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // Expected letter of a keyword at a position; false wraps modulo five.
  function automatic logic [7:0] keyword_char(input kind_t k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (k == K_FALSE) begin
      unique case (pos)
        3'd0, 3'd5: ch = 8'h66;
        3'd1, 3'd6: ch = 8'h61;
        3'd2, 3'd7: ch = 8'h6C;
        3'd3:       ch = 8'h73;
        default:    ch = 8'h65;
      endcase
    end else if (k == K_NULL) begin
      unique case (pos[1:0])
        2'd0:    ch = 8'h6E;
        2'd1:    ch = 8'h75;
        default: ch = 8'h6C;
      endcase
    end else begin
      unique case (pos[1:0])
        2'd0:    ch = 8'h74;
        2'd1:    ch = 8'h72;
        2'd2:    ch = 8'h75;
        default: ch = 8'h65;
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/json_scalar_token_scanner.sv =====
// JSON scalar scanner: input register, one-step lexer logic and result register.
// An item's result is registered in the result register once that register can advance.
// Throughput: one item per cycle unless out_stall holds a result; state updates in one step.
// While a finished result waits, the input register takes a new item only if it is empty.
// Synchronous active-low reset returns the scanner to idle with both stages empty.
`include "json_scalar_token_scanner_macros.svh"

module json_scalar_token_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_begin_req,
  input  logic       in_at_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_consumed,
  output logic       out_done_res,
  output jsts_pkg::kind_t out_kind,
  output jsts_pkg::err_t  out_error_code
);
  import jsts_pkg::*;

  // Input stage
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_begin_r;
  logic       in_end_r;

  // Scanner state
  phase_t     phase_r, phase_nxt;
  logic [2:0] kpos_r, kpos_nxt;
  kind_t      tkind_r, tkind_nxt;
  logic       bad_esc_r, bad_esc_nxt;

  // Result stage
  logic       out_vld_r;
  logic [7:0] ob_r;
  logic       ov_r, cons_r, done_r;
  kind_t      kind_r;
  err_t       err_r;

  logic       advance, proc;
  logic [7:0] ob_nxt;
  logic       ov_nxt, cons_nxt, done_nxt;
  err_t       err_nxt;

  assign advance  = !out_vld_r || !out_stall;
  assign proc     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  always_comb begin
    phase_t     ph;
    logic [2:0] kp;
    logic [2:0] klen;
    logic [7:0] want;
    logic [8:0] esc;
    logic [7:0] c;
    logic       e;
    ph          = phase_r;
    kp          = kpos_r;
    tkind_nxt   = tkind_r;
    bad_esc_nxt = bad_esc_r;
    c           = in_byte_r;
    e           = in_end_r;
    if (in_begin_r) begin
      ph          = PH_IDLE;
      kp          = 3'd0;
      tkind_nxt   = K_STRING;
      bad_esc_nxt = 1'b0;
    end
    phase_nxt = ph;
    kpos_nxt  = kp;
    ob_nxt    = 8'd0;
    ov_nxt    = 1'b0;
    cons_nxt  = 1'b0;
    done_nxt  = 1'b0;
    err_nxt   = ERR_OK;
    klen      = keyword_len(tkind_nxt);
    want      = keyword_char(tkind_nxt, kp);
    esc       = map_escape(c);

    unique case (ph)
      PH_IDLE: begin
        if (!e) begin
          cons_nxt = 1'b1;
          if (is_space(c)) begin
            phase_nxt = PH_IDLE;
          end else if (c == CH_QUOTE) begin
            tkind_nxt   = K_STRING;
            bad_esc_nxt = 1'b0;
            phase_nxt   = PH_STR;
          end else if (c == CH_MINUS) begin
            tkind_nxt = K_NUMBER;
            phase_nxt = PH_NUM_SIGN;
          end else if (is_digit(c)) begin
            tkind_nxt = K_NUMBER;
            phase_nxt = PH_NUM_INT;
          end else if (c == CH_LOW_T || c == CH_LOW_F || c == CH_LOW_N) begin
            tkind_nxt = (c == CH_LOW_T) ? K_TRUE : (c == CH_LOW_F) ? K_FALSE : K_NULL;
            kpos_nxt  = 3'd1;
            phase_nxt = PH_KEYWORD;
          end else begin
            cons_nxt  = 1'b0;
            done_nxt  = 1'b1;
            err_nxt   = ERR_BAD_START;
            tkind_nxt = K_STRING;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_STR: begin
        if (e) begin
          done_nxt  = 1'b1;
          err_nxt   = ERR_UNTERM;
          phase_nxt = PH_DONE;
        end else begin
          cons_nxt = 1'b1;
          if (c == CH_QUOTE) begin
            done_nxt  = 1'b1;
            err_nxt   = bad_esc_nxt ? ERR_BAD_ESCAPE : ERR_OK;
            phase_nxt = PH_DONE;
          end else if (c == CH_BSLASH) begin
            phase_nxt = PH_STR_ESC;
          end else begin
            ob_nxt = c;
            ov_nxt = 1'b1;
          end
        end
      end
      PH_STR_ESC: begin
        if (e) begin
          done_nxt  = 1'b1;
          err_nxt   = ERR_UNTERM;
          phase_nxt = PH_DONE;
        end else begin
          cons_nxt  = 1'b1;
          phase_nxt = PH_STR;
          if (esc[8]) begin
            ob_nxt = esc[7:0];
            ov_nxt = 1'b1;
          end else begin
            bad_esc_nxt = 1'b1;
          end
        end
      end
      PH_NUM_SIGN, PH_NUM_DOT, PH_NUM_ESGN: begin
        if (!e && is_digit(c)) begin
          cons_nxt  = 1'b1;
          phase_nxt = (ph == PH_NUM_SIGN) ? PH_NUM_INT :
                      (ph == PH_NUM_DOT)  ? PH_NUM_FRAC : PH_NUM_EXP;
        end else begin
          done_nxt  = 1'b1;
          err_nxt   = ERR_BAD_NUMBER;
          phase_nxt = PH_DONE;
        end
      end
      PH_NUM_E: begin
        if (!e && (is_digit(c) || c == CH_PLUS || c == CH_MINUS)) begin
          cons_nxt  = 1'b1;
          phase_nxt = is_digit(c) ? PH_NUM_EXP : PH_NUM_ESGN;
        end else begin
          done_nxt  = 1'b1;
          err_nxt   = ERR_BAD_NUMBER;
          phase_nxt = PH_DONE;
        end
      end
      PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP: begin
        if (!e && is_digit(c)) begin
          cons_nxt = 1'b1;
        end else if (!e && c == CH_DOT && ph == PH_NUM_INT) begin
          cons_nxt  = 1'b1;
          phase_nxt = PH_NUM_DOT;
        end else if (!e && (c == CH_LOW_E || c == CH_UP_E) && ph != PH_NUM_EXP) begin
          cons_nxt  = 1'b1;
          phase_nxt = PH_NUM_E;
        end else begin
          // The terminating byte is left for the caller.
          done_nxt  = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      PH_KEYWORD: begin
        if (!e && c == want && kp < klen) begin
          cons_nxt = 1'b1;
          kpos_nxt = kp + 3'd1;
          if ((kp + 3'd1) >= klen) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_DONE;
          end
        end else begin
          done_nxt  = 1'b1;
          err_nxt   = (tkind_nxt == K_NULL) ? ERR_BAD_NULL : ERR_BAD_BOOLEAN;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_IDLE;
      kpos_r    <= 3'd0;
      tkind_r   <= K_STRING;
      bad_esc_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (proc) begin
        phase_r   <= phase_nxt;
        kpos_r    <= kpos_nxt;
        tkind_r   <= tkind_nxt;
        bad_esc_r <= bad_esc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r  <= in_data_byte;
      in_begin_r <= in_begin_req;
      in_end_r   <= in_at_end;
    end
    if (proc) begin
      ob_r   <= ob_nxt;
      ov_r   <= ov_nxt;
      cons_r <= cons_nxt;
      done_r <= done_nxt;
      kind_r <= tkind_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_out_byte   = ob_r;
  assign out_out_valid  = ov_r;
  assign out_consumed   = cons_r;
  assign out_done_res   = done_r;
  assign out_kind       = kind_r;
  assign out_error_code = err_r;

  `JSTS_ASSERT_NOW(a_err_only_when_done, clk, rst_n, out_vld_r && err_r != ERR_OK, done_r)
  `JSTS_ASSERT_NOW(a_char_is_consumed, clk, rst_n, out_vld_r && ov_r, cons_r && kind_r == K_STRING)
  `JSTS_ASSERT_NEXT(a_done_enters_done, clk, rst_n, proc && done_nxt, phase_r == PH_DONE)
  `JSTS_ASSERT_NEXT(a_held_item_kept, clk, rst_n, in_stall, in_vld_r && out_vld_r)

endmodule
